[rtl/bde_pkg.sv]
package bde_pkg;

    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int READ_MAX  = 16;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    // command codes
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_REMOVE     = 3'd5;
    localparam logic [MODE_W-1:0] MODE_READ_FRONT = 3'd6;
    localparam logic [MODE_W-1:0] MODE_READ_BACK  = 3'd7;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [WORD_BITS-1:0] word_t;

    // request to the shared slot / compare unit
    typedef struct packed {
        idx_t  base;
        idx_t  offset;
        word_t cmp_a;
        word_t cmp_b;
    } unit_req_t;

    typedef struct packed {
        idx_t slot;
        logic equal;
    } unit_res_t;

endpackage

[rtl/bde_cmd_if.sv]
interface bde_cmd_if
    import bde_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [MODE_W-1:0]          mode;
    logic signed [VALUE_W-1:0]  value;
    logic [COUNT_W-1:0]         count;

    modport source (output valid, output mode, output value, output count, input ready);
    modport sink   (input valid, input mode, input value, input count, output ready);
endinterface

[rtl/bde_rsp_if.sv]
interface bde_rsp_if
    import bde_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  item_value;
    logic                       last;
    logic [STATUS_W-1:0]        status;

    modport source (output valid, output item_value, output last, output status, input ready);
    modport sink   (input valid, input item_value, input last, input status, output ready);
endinterface

[rtl/bde_unit.sv]
module bde_unit
    import bde_pkg::*;
(
    input  unit_req_t req,
    output unit_res_t res
);

    logic [IDX_W:0] sum;

    // circular slot: base plus offset, folded once since both are below depth
    always_comb
    begin
        sum = {1'b0, req.base} + {1'b0, req.offset};
        if (sum >= (IDX_W + 1)'(DEPTH))
        begin
            sum = sum - (IDX_W + 1)'(DEPTH);
        end
        res.slot  = sum[IDX_W-1:0];
        res.equal = (req.cmp_a == req.cmp_b);
    end

endmodule

[rtl/bounded_deque_engine.sv]
// bounded double-ended queue of signed words, held in a circular store
//
// cmd channel: one transaction carries mode, value and count. ready is high
// only while the engine is idle; each command is worked through to the end
// before the next one is taken
// rsp channel: one transaction per result; item_value, last and status.
// every command gives one result, a read gives min(count, fill, 16) results
// with last set on the final one (one result when the store is empty or
// count is zero)
// timing: push, clear and the full/empty cases give their result from the
// execute step, a pop and each read result take a store read first, and a
// value removal reads and writes back each entry; the store and the shared
// slot unit are used once per step
// reset: head and fill go to zero, no result pending; the store itself is
// not cleared, only written positions are ever read
// stall: results sit in an output register; while the receiver holds ready
// low the sequencer waits at the step that produces the next result
module bounded_deque_engine
    import bde_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    bde_cmd_if.sink   cmd,
    bde_rsp_if.source rsp
);

    localparam int STATE_W = 3;
    localparam logic [STATE_W-1:0] S_IDLE    = 3'd0;
    localparam logic [STATE_W-1:0] S_EXEC    = 3'd1;
    localparam logic [STATE_W-1:0] S_POP_OUT = 3'd2;
    localparam logic [STATE_W-1:0] S_RM_RD   = 3'd3;
    localparam logic [STATE_W-1:0] S_RM_WR   = 3'd4;
    localparam logic [STATE_W-1:0] S_RD_ADDR = 3'd5;
    localparam logic [STATE_W-1:0] S_RD_OUT  = 3'd6;

    // control state
    logic [STATE_W-1:0] state_reg, state_next;
    idx_t               head_reg, head_next;
    cnt_t               fill_reg, fill_next;
    cnt_t               idx_reg, idx_next;     // walk position
    cnt_t               kept_reg, kept_next;   // entries kept during removal
    cnt_t               n_reg, n_next;         // results to give for a read
    logic               rsp_valid_reg, rsp_valid_next;

    // payload registers
    logic [MODE_W-1:0]         mode_reg;
    word_t                     word_reg;
    logic [COUNT_W-1:0]        count_reg;
    word_t                     rd_data_reg;
    logic signed [VALUE_W-1:0] item_reg, item_next;
    logic                      last_reg, last_next;
    logic [STATUS_W-1:0]       status_reg, status_next;

    // entry store
    word_t store_mem [DEPTH];
    logic  mem_we;
    idx_t  mem_wa;
    word_t mem_wd;
    logic  mem_re;
    idx_t  mem_ra;

    unit_req_t unit_req;
    unit_res_t unit_res;

    logic    accept;
    logic    out_free;
    logic    emit;
    logic    front;
    cnt_t    lim;
    cnt_t    n_calc;

    bde_unit u_unit (
        .req (unit_req),
        .res (unit_res)
    );

    assign accept   = cmd.valid && cmd.ready;
    assign out_free = !rsp_valid_reg || rsp.ready;

    assign cmd.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.item_value = item_reg;
    assign rsp.last       = last_reg;
    assign rsp.status     = status_reg;

    // number of entries a read gives: min(count, fill, READ_MAX)
    always_comb
    begin
        if (32'(fill_reg) < 32'(READ_MAX))
        begin
            lim = fill_reg;
        end
        else
        begin
            lim = CNT_W'(READ_MAX);
        end
        if (32'(count_reg) < 32'(lim))
        begin
            n_calc = CNT_W'(count_reg);
        end
        else
        begin
            n_calc = lim;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        kept_next      = kept_reg;
        n_next         = n_reg;
        emit           = 1'b0;
        item_next      = '0;
        last_next      = 1'b1;
        status_next    = ST_OK;
        mem_we         = 1'b0;
        mem_wa         = unit_res.slot;
        mem_wd         = word_reg;
        mem_re         = 1'b0;
        mem_ra         = unit_res.slot;
        front          = (mode_reg == MODE_PUSH_FRONT) || (mode_reg == MODE_POP_FRONT)
                         || (mode_reg == MODE_READ_FRONT);
        unit_req.base  = head_reg;
        unit_req.offset = '0;
        unit_req.cmp_a = rd_data_reg;
        unit_req.cmp_b = word_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                case (mode_reg)
                    MODE_PUSH_FRONT, MODE_PUSH_BACK:
                    begin
                        if (front)
                        begin
                            unit_req.offset = IDX_W'(DEPTH - 1);
                        end
                        else
                        begin
                            unit_req.offset = IDX_W'(fill_reg);
                        end
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                            if (32'(fill_reg) >= 32'(DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                fill_next = fill_reg + 1'b1;
                                if (front)
                                begin
                                    head_next = unit_res.slot;
                                end
                            end
                        end
                    end

                    MODE_POP_FRONT, MODE_POP_BACK:
                    begin
                        if (fill_reg == '0)
                        begin
                            if (out_free)
                            begin
                                emit        = 1'b1;
                                status_next = ST_EMPTY;
                                state_next  = S_IDLE;
                            end
                        end
                        else
                        begin
                            // front: read at head, unit gives the new head
                            mem_re = 1'b1;
                            if (front)
                            begin
                                unit_req.offset = IDX_W'(1);
                                mem_ra          = head_reg;
                                head_next       = unit_res.slot;
                            end
                            else
                            begin
                                unit_req.offset = IDX_W'(fill_reg - 1'b1);
                            end
                            fill_next  = fill_reg - 1'b1;
                            state_next = S_POP_OUT;
                        end
                    end

                    MODE_CLEAR:
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            fill_next  = '0;
                            head_next  = '0;
                            state_next = S_IDLE;
                        end
                    end

                    MODE_REMOVE:
                    begin
                        idx_next   = '0;
                        kept_next  = '0;
                        state_next = S_RM_RD;
                    end

                    default:
                    begin
                        // the two read modes
                        if (fill_reg == '0 || n_calc == '0)
                        begin
                            if (out_free)
                            begin
                                emit        = 1'b1;
                                status_next = (fill_reg == '0) ? ST_EMPTY : ST_OK;
                                state_next  = S_IDLE;
                            end
                        end
                        else
                        begin
                            n_next     = n_calc;
                            idx_next   = '0;
                            state_next = S_RD_ADDR;
                        end
                    end
                endcase
            end

            S_POP_OUT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    item_next  = VALUE_W'(rd_data_reg);
                    state_next = S_IDLE;
                end
            end

            S_RM_RD:
            begin
                if (idx_reg == fill_reg)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        fill_next  = kept_reg;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    unit_req.offset = IDX_W'(idx_reg);
                    mem_re          = 1'b1;
                    state_next      = S_RM_WR;
                end
            end

            S_RM_WR:
            begin
                // keep the entry unless it matches, packed toward the front
                unit_req.offset = IDX_W'(kept_reg);
                mem_wd          = rd_data_reg;
                if (!unit_res.equal)
                begin
                    mem_we    = 1'b1;
                    kept_next = kept_reg + 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_RM_RD;
            end

            S_RD_ADDR:
            begin
                if (front)
                begin
                    unit_req.offset = IDX_W'(idx_reg);
                end
                else
                begin
                    unit_req.offset = IDX_W'(fill_reg - 1'b1 - idx_reg);
                end
                mem_re     = 1'b1;
                state_next = S_RD_OUT;
            end

            S_RD_OUT:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    item_next = VALUE_W'(rd_data_reg);
                    last_next = (idx_reg + 1'b1 == n_reg);
                    idx_next  = idx_reg + 1'b1;
                    if (idx_reg + 1'b1 == n_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_RD_ADDR;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // output register: load on a new result, drop once taken
        if (emit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            idx_reg       <= '0;
            kept_reg      <= '0;
            n_reg         <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            kept_reg      <= kept_next;
            n_reg         <= n_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // command capture, result payload and store port
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= cmd.mode;
            word_reg  <= WORD_BITS'(cmd.value);
            count_reg <= cmd.count;
        end
        if (emit)
        begin
            item_reg   <= item_next;
            last_reg   <= last_next;
            status_reg <= status_next;
        end
        if (mem_we)
        begin
            store_mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= store_mem[mem_ra];
        end
    end

endmodule
